FILE: src/afv_pkg.sv
// ----------------------------------------------------------------------------
// afv_pkg
// Shared constants, types and register reset values for the box visibility
// pipeline.
// ----------------------------------------------------------------------------
package afv_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int FIELD_W      = 32;
  localparam int NUM_AXES     = 3;
  localparam int NUM_COLS     = 4;
  localparam int NUM_CORNERS  = 8;
  localparam int NUM_MAT_REGS = 8;
  localparam int REG_W        = 64;
  localparam int HALF_W       = 32;
  localparam int REG_IDX_W    = 3;
  localparam int CFG_ADDR_W   = 6;

  localparam int IN_DATA_W  = 2 * NUM_AXES * FIELD_W;
  localparam int OUT_DATA_W = 8;
  localparam int CNT_W      = 4;

  // Bit positions of the result fields in the output word.
  localparam int OUT_VIS_BIT   = 0;
  localparam int OUT_FRONT_LSB = 1;
  localparam int OUT_SCR_BIT   = 5;

  typedef logic [NUM_MAT_REGS-1:0][REG_W-1:0] mat_regs_t;

  // Identity matrix, 1.0 written as 0x10000 in each diagonal half.
  localparam mat_regs_t MAT_RESET = '{
    64'h0000_0000_0001_0000,  // row 4, col 3 and 4
    64'h0000_0000_0000_0000,  // row 4, col 1 and 2
    64'h0001_0000_0000_0000,  // row 3, col 3 and 4
    64'h0000_0000_0000_0000,  // row 3, col 1 and 2
    64'h0000_0000_0000_0000,  // row 2, col 3 and 4
    64'h0000_0000_0001_0000,  // row 2, col 1 and 2
    64'h0000_0000_0000_0000,  // row 1, col 3 and 4
    64'h0001_0000_0000_0000   // row 1, col 1 and 2
  };

  // Per-corner compare results.
  typedef struct packed {
    logic front;   // -w <= z <= w
    logic scr;     // front and x, y inside [-w, w]
    logic xp;      // x > |w|
    logic xn;      // x < -|w|
    logic yp;      // y > |w|
    logic yn;      // y < -|w|
  } corner_flags_t;

  // Result word, laid out so that it packs straight into tdata.
  typedef struct packed {
    logic             corner_on_screen;
    logic [CNT_W-1:0] front_corners;
    logic             is_visible;
  } afv_result_t;

endpackage

FILE: src/afv_xform.sv
// ----------------------------------------------------------------------------
// afv_xform
// Three-stage transform: per-axis products, partial sums, then the clip
// coordinates of all eight box corners.
// ----------------------------------------------------------------------------
module afv_xform
  import afv_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FW = FRAC_BITS_DEF,
  parameter int SW = 2 * COORD_WIDTH_DEF + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] lo_i [NUM_AXES],
  input  logic signed [CW-1:0] hi_i [NUM_AXES],
  input  mat_regs_t            mat_i,
  output logic                 crd_valid_o,
  output logic signed [SW-1:0] crd_o [NUM_CORNERS][NUM_COLS]
);

  localparam int PW = 2 * CW;

  logic signed [CW-1:0] mcoef [NUM_COLS][NUM_COLS];  // [row][col]
  logic signed [PW-1:0] mcoef_ext [NUM_COLS][NUM_COLS];
  logic signed [PW-1:0] lo_ext [NUM_AXES];
  logic signed [PW-1:0] hi_ext [NUM_AXES];
  logic signed [SW-1:0] trans [NUM_COLS];

  logic signed [PW-1:0] prod_lo_r [NUM_COLS][NUM_AXES];
  logic signed [PW-1:0] prod_hi_r [NUM_COLS][NUM_AXES];
  logic signed [SW-1:0] xy_r [NUM_COLS][4];
  logic signed [SW-1:0] zt_r [NUM_COLS][2];
  logic signed [SW-1:0] crd_r [NUM_CORNERS][NUM_COLS];
  logic                 v1_r, v2_r, v3_r;

  genvar gr, gc;
  for (gr = 0; gr < NUM_COLS; gr++) begin : g_row
    for (gc = 0; gc < NUM_COLS; gc++) begin : g_col
      // Odd columns sit in the low half of a register, even ones in the high half.
      if (gc % 2 == 1) begin : g_low
        assign mcoef[gr][gc] = mat_i[2*gr + gc/2][CW-1:0];
      end else begin : g_high
        assign mcoef[gr][gc] = mat_i[2*gr + gc/2][HALF_W+CW-1:HALF_W];
      end
      assign mcoef_ext[gr][gc] = PW'(mcoef[gr][gc]);
    end
  end

  for (gc = 0; gc < NUM_AXES; gc++) begin : g_ext
    assign lo_ext[gc] = PW'(lo_i[gc]);
    assign hi_ext[gc] = PW'(hi_i[gc]);
  end

  // The homogeneous 1 turns the last row into a shifted constant.
  for (gc = 0; gc < NUM_COLS; gc++) begin : g_trans
    assign trans[gc] = SW'(mcoef[NUM_COLS-1][gc]) <<< FW;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          prod_lo_r[c][a] <= mcoef_ext[a][c] * lo_ext[a];
          prod_hi_r[c][a] <= mcoef_ext[a][c] * hi_ext[a];
        end
      end
    end
  end

  // Stage two: the four x/y combinations and the two z choices with translation.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        for (int k = 0; k < 4; k++) begin
          xy_r[c][k] <= SW'(((k & 1) != 0) ? prod_hi_r[c][0] : prod_lo_r[c][0]) +
                        SW'(((k & 2) != 0) ? prod_hi_r[c][1] : prod_lo_r[c][1]);
        end
        for (int k = 0; k < 2; k++) begin
          zt_r[c][k] <= SW'((k == 1) ? prod_hi_r[c][2] : prod_lo_r[c][2]) + trans[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NUM_CORNERS; n++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          crd_r[n][c] <= xy_r[c][2'(n)] + zt_r[c][1'(n >> 2)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign crd_valid_o = v3_r;
  assign crd_o       = crd_r;

endmodule

FILE: src/afv_judge.sv
// ----------------------------------------------------------------------------
// afv_judge
// Three-stage clip test: w magnitude, per-corner compares, then the corner
// count and the visibility decision into the output register.
// ----------------------------------------------------------------------------
module afv_judge
  import afv_pkg::*;
#(
  parameter int SW = 2 * COORD_WIDTH_DEF + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 crd_valid_i,
  input  logic signed [SW-1:0] crd_i [NUM_CORNERS][NUM_COLS],
  output logic                 res_valid_o,
  output afv_result_t          res_o
);

  logic signed [SW-1:0] x4_r [NUM_CORNERS];
  logic signed [SW-1:0] y4_r [NUM_CORNERS];
  logic signed [SW-1:0] z4_r [NUM_CORNERS];
  logic signed [SW-1:0] w4_r [NUM_CORNERS];
  logic signed [SW-1:0] nw4_r [NUM_CORNERS];
  logic signed [SW-1:0] aw4_r [NUM_CORNERS];
  logic signed [SW-1:0] naw4_r [NUM_CORNERS];
  corner_flags_t        flg5_r [NUM_CORNERS];
  afv_result_t          res_r;
  afv_result_t          res_nxt;
  logic                 v4_r, v5_r, v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NUM_CORNERS; n++) begin
        x4_r[n]  <= crd_i[n][0];
        y4_r[n]  <= crd_i[n][1];
        z4_r[n]  <= crd_i[n][2];
        w4_r[n]  <= crd_i[n][3];
        nw4_r[n] <= -crd_i[n][3];
        aw4_r[n] <= crd_i[n][3][SW-1] ? -crd_i[n][3] : crd_i[n][3];
        naw4_r[n] <= crd_i[n][3][SW-1] ? crd_i[n][3] : -crd_i[n][3];
      end
    end
  end

  // A coordinate weighs two with its sign when it lies outside [-|w|, |w|].
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NUM_CORNERS; n++) begin
        flg5_r[n].front <= (nw4_r[n] <= z4_r[n]) && (z4_r[n] <= w4_r[n]);
        flg5_r[n].scr   <= (nw4_r[n] <= z4_r[n]) && (z4_r[n] <= w4_r[n]) &&
                           (nw4_r[n] <= x4_r[n]) && (x4_r[n] <= w4_r[n]) &&
                           (nw4_r[n] <= y4_r[n]) && (y4_r[n] <= w4_r[n]);
        flg5_r[n].xp    <= x4_r[n] > aw4_r[n];
        flg5_r[n].xn    <= x4_r[n] < naw4_r[n];
        flg5_r[n].yp    <= y4_r[n] > aw4_r[n];
        flg5_r[n].yn    <= y4_r[n] < naw4_r[n];
      end
    end
  end

  // An axis sum reaches magnitude 16 only when all corners weigh two with the
  // same sign, so the sums reduce to an AND over the flags.
  always_comb begin
    logic all_xp, all_xn, all_yp, all_yn, any_scr;
    logic [CNT_W-1:0] cnt;
    all_xp  = 1'b1;
    all_xn  = 1'b1;
    all_yp  = 1'b1;
    all_yn  = 1'b1;
    any_scr = 1'b0;
    cnt     = '0;
    for (int n = 0; n < NUM_CORNERS; n++) begin
      all_xp  = all_xp & flg5_r[n].xp;
      all_xn  = all_xn & flg5_r[n].xn;
      all_yp  = all_yp & flg5_r[n].yp;
      all_yn  = all_yn & flg5_r[n].yn;
      any_scr = any_scr | flg5_r[n].scr;
      cnt     = cnt + CNT_W'(flg5_r[n].front);
    end
    res_nxt.front_corners    = cnt;
    res_nxt.corner_on_screen = any_scr;
    res_nxt.is_visible       = any_scr ||
                               ((cnt != '0) && !all_xp && !all_xn && !all_yp && !all_yn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= crd_valid_i;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign res_valid_o = v6_r;
  assign res_o       = res_r;

endmodule

FILE: src/aabb_frustum_visibility_top.sv
// Pipeline: a word accepted on the input passes through six register stages
// before its result reaches out_tdata.
// Throughput: one box per cycle; the six pipeline stages advance together and
// hold as a whole only while the output word waits on out_tready.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// matrix into the eight matrix registers.
// ----------------------------------------------------------------------------
// aabb_frustum_visibility_top
// Clip-space visibility test of an axis-aligned box against a configured
// 4x4 matrix, with a 64-bit register port for the matrix.
// ----------------------------------------------------------------------------
module aabb_frustum_visibility_top
  import afv_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, 32 bits each from bit 0 up
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // is_visible, front_corners (4 bits), corner_on_screen, 2 zero bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [REG_W-1:0]      cfg_pwdata,
  output logic [REG_W-1:0]      cfg_prdata,
  output logic                  cfg_pready
);

  localparam int TW = COORD_WIDTH + FRAC_BITS;
  localparam int PW = 2 * COORD_WIDTH;
  localparam int BW = (TW > PW) ? TW : PW;
  localparam int SW = BW + 3;

  mat_regs_t                     mat_r;
  logic [REG_IDX_W-1:0]          reg_idx;
  logic                          en;
  logic signed [COORD_WIDTH-1:0] lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi [NUM_AXES];
  logic                          crd_valid;
  logic signed [SW-1:0]          crd [NUM_CORNERS][NUM_COLS];
  afv_result_t                   res;

  // Register port: one 64-bit matrix register per 8-byte slot.
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = mat_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= MAT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      mat_r[reg_idx] <= cfg_pwdata;
    end
  end

  // The whole pipeline moves whenever the output register is free or drains.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  genvar ga;
  for (ga = 0; ga < NUM_AXES; ga++) begin : g_fields
    assign lo[ga] = in_tdata[ga*FIELD_W +: COORD_WIDTH];
    assign hi[ga] = in_tdata[(ga+NUM_AXES)*FIELD_W +: COORD_WIDTH];
  end

  afv_xform #(
    .CW (COORD_WIDTH),
    .FW (FRAC_BITS),
    .SW (SW)
  ) u_xform (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .lo_i        (lo),
    .hi_i        (hi),
    .mat_i       (mat_r),
    .crd_valid_o (crd_valid),
    .crd_o       (crd)
  );

  afv_judge #(
    .SW (SW)
  ) u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .crd_valid_i (crd_valid),
    .crd_i       (crd),
    .res_valid_o (out_tvalid),
    .res_o       (res)
  );

  assign out_tdata = {(OUT_DATA_W - $bits(afv_result_t))'(0), res};

endmodule

FILE: src/afv_checker.sv
// ----------------------------------------------------------------------------
// afv_checker
// Port-level checks on the result stream of the box visibility block.
// ----------------------------------------------------------------------------
module afv_checker
  import afv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed or dropped while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_FRONT_LSB +: CNT_W] <= CNT_W'(NUM_CORNERS))
    else $error("front corner count above eight");

  a_scr_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_SCR_BIT] |-> out_tdata[OUT_VIS_BIT])
    else $error("on-screen corner but box reported culled");

  a_scr_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_SCR_BIT] |-> out_tdata[OUT_FRONT_LSB +: CNT_W] != '0)
    else $error("on-screen corner without any front corner");

  a_nofront_culled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FRONT_LSB +: CNT_W] == '0 |-> !out_tdata[OUT_VIS_BIT])
    else $error("box with no front corner reported visible");

endmodule

bind aabb_frustum_visibility_top afv_checker u_afv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/aabb_frustum_visibility_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_frustum_visibility_top_tb
// Self-checking bench for the box visibility pipeline. Boxes are streamed in
// under a series of matrix settings written over the register port, and each
// result word is checked against its box's own expectation or a cycle-free
// clip-space model that keeps every product and sum at full width.
// ----------------------------------------------------------------------------
module aabb_frustum_visibility_top_tb;
  import afv_pkg::*;

  localparam int          LATENCY           = 6;
  localparam int          ITEMS_PER_SETTING = 43;
  localparam int          LONG_HOLD         = 250;
  localparam int unsigned CYCLE_LIMIT       = 300000;

  typedef logic signed [31:0]  coord_t;
  typedef logic signed [127:0] wide_t;

  // Field order puts lo_x in the lowest bits, matching in_tdata.
  typedef struct packed {
    coord_t hi_z;
    coord_t hi_y;
    coord_t hi_x;
    coord_t lo_z;
    coord_t lo_y;
    coord_t lo_x;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic        has_want;
    afv_result_t want;
  } offer_t;

  typedef enum int {
    MAT_R1_C12 = 0,
    MAT_R1_C34 = 1,
    MAT_R2_C12 = 2,
    MAT_R2_C34 = 3,
    MAT_R3_C12 = 4,
    MAT_R3_C34 = 5,
    MAT_R4_C12 = 6,
    MAT_R4_C34 = 7
  } mat_reg_e;

  typedef enum int {
    SET_PERSPECTIVE,
    SET_ZERO_W,
    SET_MAX_POS,
    SET_MAX_NEG,
    SET_ALL_ONES,
    SET_ALL_ZERO,
    SET_RANDOM_A,
    SET_RANDOM_B,
    SET_RANDOM_C,
    SET_IDENTITY,
    NUM_SETTINGS
  } matrix_setting_e;

  localparam coord_t     Q_ONE  = 32'sh0001_0000;
  localparam logic [63:0] ONE_HI = 64'h0001_0000_0000_0000;
  localparam logic [63:0] ONE_LO = 64'h0000_0000_0001_0000;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, 32 bits each from bit 0 up
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // is_visible, front_corners (4 bits), corner_on_screen, 2 zero bits
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [REG_W-1:0]      cfg_pwdata  = '0;
  logic [REG_W-1:0]      cfg_prdata;
  logic                  cfg_pready;

  logic [63:0]  matrix_model [NUM_MAT_REGS];
  logic [63:0]  next_matrix  [NUM_MAT_REGS];
  offer_t       boxes_offered [$];
  offer_t       directed_rows [$];
  afv_result_t  visibility_due [$];
  int           mismatch_cnt  = 0;
  int           result_cnt    = 0;
  int unsigned  cycle_cnt     = 0;
  bit           calm_traffic  = 1'b0;
  bit           hold_request  = 1'b0;

  aabb_frustum_visibility_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------- model
  function automatic coord_t mat_entry(input int row, input int col);
    logic [63:0] r;
    r = matrix_model[row * 2 + col / 2];
    return (col % 2 != 0) ? coord_t'(r[31:0]) : coord_t'(r[63:32]);
  endfunction

  // Signed weight of one clip coordinate: 2 outside |w|, 1 inside.
  function automatic int axis_weight(input wide_t v, input wide_t aw);
    wide_t av;
    int    mag;
    av  = (v < 0) ? -v : v;
    mag = (av <= aw) ? 1 : 2;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic afv_result_t predict_visibility(input box_t b);
    coord_t      p [3];
    wide_t       clip [4];
    wide_t       nw;
    wide_t       aw;
    int          xsum;
    int          ysum;
    int          front;
    logic        on_scr;
    logic        in_front;
    afv_result_t r;
    xsum   = 0;
    ysum   = 0;
    front  = 0;
    on_scr = 1'b0;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      p[0] = c[0] ? b.hi_x : b.lo_x;
      p[1] = c[1] ? b.hi_y : b.lo_y;
      p[2] = c[2] ? b.hi_z : b.lo_z;
      for (int k = 0; k < NUM_COLS; k++) begin
        clip[k] = wide_t'(mat_entry(0, k)) * wide_t'(p[0])
                + wide_t'(mat_entry(1, k)) * wide_t'(p[1])
                + wide_t'(mat_entry(2, k)) * wide_t'(p[2])
                + (wide_t'(mat_entry(3, k)) <<< FRAC_BITS_DEF);
      end
      nw       = -clip[3];
      aw       = (clip[3] < 0) ? nw : clip[3];
      in_front = (nw <= clip[2]) && (clip[2] <= clip[3]);
      if (in_front) begin
        front++;
        if (nw <= clip[0] && clip[0] <= clip[3] && nw <= clip[1] && clip[1] <= clip[3])
          on_scr = 1'b1;
      end
      xsum += axis_weight(clip[0], aw);
      ysum += axis_weight(clip[1], aw);
    end
    r.is_visible       = on_scr || (front > 0 && xsum != 16 && xsum != -16 &&
                                    ysum != 16 && ysum != -16);
    r.front_corners    = front[CNT_W-1:0];
    r.corner_on_screen = on_scr;
    return r;
  endfunction

  // ------------------------------------------------------------- monitors
  always @(posedge clk) begin
    offer_t o;
    if (rst_n && in_tvalid && in_tready && boxes_offered.size() != 0) begin
      o = boxes_offered.pop_front();
      visibility_due.push_back(o.has_want ? o.want : predict_visibility(o.box));
    end
  end

  always @(posedge clk) begin
    afv_result_t got;
    afv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[5:0];
      if (visibility_due.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing pending", result_cnt));
      end else begin
        want = visibility_due.pop_front();
        if (got.is_visible !== want.is_visible)
          report_mismatch($sformatf("word %0d is_visible %b, expected %b",
                                    result_cnt, got.is_visible, want.is_visible));
        if (got.front_corners !== want.front_corners)
          report_mismatch($sformatf("word %0d front_corners %0d, expected %0d",
                                    result_cnt, got.front_corners, want.front_corners));
        if (got.corner_on_screen !== want.corner_on_screen)
          report_mismatch($sformatf("word %0d corner_on_screen %b, expected %b",
                                    result_cnt, got.corner_on_screen,
                                    want.corner_on_screen));
      end
      result_cnt++;
    end
  end

  // ------------------------------------------------------------- stimulus
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    if (calm_traffic || $urandom_range(0, 1) == 0)
      return 0;
    return idle_len();
  endfunction

  // Receiver: random stalls, one long hold-off on request, none in calm phases.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (calm_traffic || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      3, 4, 5, 6: return coord_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly well-ordered boxes of modest size; sometimes two unrelated corners.
  function automatic coord_t rand_upper(input coord_t lo);
    if ($urandom_range(0, 9) < 7)
      return lo + coord_t'($urandom_range(0, 32'h3_0000));
    return rand_coord();
  endfunction

  function automatic box_t rand_box();
    box_t b;
    b.lo_x = rand_coord();
    b.lo_y = rand_coord();
    b.lo_z = rand_coord();
    b.hi_x = rand_upper(b.lo_x);
    b.hi_y = rand_upper(b.lo_y);
    b.hi_z = rand_upper(b.lo_z);
    return b;
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 7))
      0:       return '0;
      6:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      7:       return $urandom;
      default: return coord_t'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
    endcase
  endfunction

  function automatic void table_row(input coord_t lx, input coord_t ly, input coord_t lz,
                                    input coord_t hx, input coord_t hy, input coord_t hz,
                                    input logic has_want, input logic vis,
                                    input int front, input logic scr);
    offer_t o;
    o.box                   = '{hz, hy, hx, lz, ly, lx};
    o.has_want              = has_want;
    o.want.is_visible       = vis;
    o.want.front_corners    = front[CNT_W-1:0];
    o.want.corner_on_screen = scr;
    directed_rows.push_back(o);
  endfunction

  // Directed boxes under the identity matrix. Rows with an expectation of
  // their own carry it; the rest go through the model.
  function automatic void build_directed_rows();
    //        lo_x          lo_y          lo_z          hi_x          hi_y          hi_z
    table_row(32'sh0,       32'sh0,       32'sh0,       32'sh0,       32'sh0,       32'sh0,
              1, 1, 8, 1);
    table_row(-Q_ONE,       -Q_ONE,       -Q_ONE,       Q_ONE,        Q_ONE,        Q_ONE,
              1, 1, 8, 1);
    table_row(32'sh2_0000,  32'sh0,       32'sh0,       32'sh3_0000,  32'sh0,       32'sh0,
              1, 0, 8, 0);
    table_row(-32'sh3_0000, 32'sh0,       32'sh0,       -32'sh2_0000, 32'sh0,       32'sh0,
              1, 0, 8, 0);
    table_row(32'sh0,       32'sh2_0000,  32'sh0,       32'sh0,       32'sh3_0000,  32'sh0,
              1, 0, 8, 0);
    table_row(32'sh0,       32'sh0,       32'sh2_0000,  32'sh0,       32'sh0,       32'sh3_0000,
              1, 0, 0, 0);
    table_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, 0, 0);
    table_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 0, 0, 0);
    table_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, 0, 0);
    // Box wider than the view on x: the corner weights cancel.
    table_row(-32'sh3_0000, 32'sh0,       32'sh0,       32'sh3_0000,  32'sh0,       32'sh0,
              1, 1, 8, 0);
    // Only the near half of the box is in front, so four corners are counted.
    table_row(32'sh0,       32'sh0,       32'sh0_8000,  32'sh0,       32'sh0,       32'sh5_0000,
              1, 1, 4, 1);
    // Swapped corners on x are taken as given.
    table_row(32'sh1_8000,  32'sh0,       32'sh0,       -32'sh1_8000, 32'sh0,       32'sh0,
              1, 1, 8, 0);
    table_row(Q_ONE,        32'sh0,       32'sh0,       Q_ONE,        32'sh0,       32'sh0,
              1, 1, 8, 1);
    table_row(32'sh1_0001,  32'sh0,       32'sh0,       32'sh1_0001,  32'sh0,       32'sh0,
              1, 0, 8, 0);
    table_row(32'sh8000_0000, 32'sh0,     32'sh0,       32'sh8000_0000, 32'sh0,     32'sh0,
              1, 0, 8, 0);
    table_row(32'sh0,       32'sh0,       -32'sh1_0001, 32'sh0,       32'sh0,       -32'sh1_0001,
              1, 0, 0, 0);
    table_row(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
              32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 0, 0, 0, 0);
    table_row(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
              32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 0, 0);
    table_row(-32'sh0_8000, 32'sh1_8000,  -32'sh2_0000, 32'sh2_0000,  32'sh3_0000,  32'sh0_4000,
              0, 0, 0, 0);
    table_row(32'sh0_8000,  32'sh0_8000,  -32'sh0_4000, 32'sh1_8000,  32'sh1_8000,  32'sh0_4000,
              0, 0, 0, 0);
    table_row(32'sh1234_5678, -32'sh0_2468, 32'sh0_FEDC, -32'sh7654_3210, 32'sh0_1357,
              32'sh0_9BDF, 0, 0, 0, 0);
  endfunction

  function automatic void load_setting(input matrix_setting_e s);
    next_matrix[MAT_R1_C12] = ONE_HI;
    next_matrix[MAT_R1_C34] = '0;
    next_matrix[MAT_R2_C12] = ONE_LO;
    next_matrix[MAT_R2_C34] = '0;
    next_matrix[MAT_R3_C12] = '0;
    next_matrix[MAT_R3_C34] = ONE_HI;
    next_matrix[MAT_R4_C12] = '0;
    next_matrix[MAT_R4_C34] = ONE_LO;
    case (s)
      SET_PERSPECTIVE: begin
        // x scaled by 1.5, y by 2, w follows z, z = 1.25 z - 0.5.
        next_matrix[MAT_R1_C12] = 64'h0001_8000_0000_0000;
        next_matrix[MAT_R2_C12] = 64'h0000_0000_0002_0000;
        next_matrix[MAT_R3_C34] = 64'h0001_4000_0001_0000;
        next_matrix[MAT_R4_C34] = 64'hFFFF_8000_0000_0000;
      end
      SET_ZERO_W:   next_matrix[MAT_R4_C34] = '0;
      SET_MAX_POS:  foreach (next_matrix[i]) next_matrix[i] = 64'h7FFF_FFFF_7FFF_FFFF;
      SET_MAX_NEG:  foreach (next_matrix[i]) next_matrix[i] = 64'h8000_0000_8000_0000;
      SET_ALL_ONES: foreach (next_matrix[i]) next_matrix[i] = '1;
      SET_ALL_ZERO: foreach (next_matrix[i]) next_matrix[i] = '0;
      SET_RANDOM_A, SET_RANDOM_B, SET_RANDOM_C:
        foreach (next_matrix[i]) next_matrix[i] = {rand_entry(), rand_entry()};
      default: ;
    endcase
  endfunction

  // psel stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(input int idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx * 8);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    matrix_model[idx] = value;
  endtask

  task automatic write_matrix();
    for (int i = 0; i < NUM_MAT_REGS; i++)
      write_reg(i, next_matrix[i]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_box(input offer_t o);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= o.box;
    boxes_offered.push_back(o);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drain();
    while (boxes_offered.size() != 0 || visibility_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    matrix_setting_e setting;
    offer_t          o;
    load_setting(SET_IDENTITY);
    matrix_model = next_matrix;
    build_directed_rows();
    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (directed_rows[i])
      send_box(directed_rows[i]);
    in_tvalid <= 1'b0;

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      setting = matrix_setting_e'(s);
      wait_drain();
      load_setting(setting);
      write_matrix();
      calm_traffic = (setting == SET_RANDOM_C);
      // The pipeline fills and stalls its input during this hold-off.
      if (setting == SET_PERSPECTIVE)
        hold_request = 1'b1;
      repeat (ITEMS_PER_SETTING) begin
        o.box      = rand_box();
        o.has_want = 1'b0;
        o.want     = '0;
        send_box(o);
      end
      in_tvalid <= 1'b0;
    end

    wait_drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (visibility_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", visibility_due.size()));
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
